// ----- hdl/fsaw_pkg.sv -----
// fsaw_pkg: shared constants and the sequencer state type for the
// fcfs/sjf average wait block; no dependencies, compiled first
`default_nettype none

package fsaw_pkg;

    localparam int BURST_W       = 16;
    localparam int AVG_W         = 21;
    localparam int MAX_PROCS_DEF = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/fcfs_sjf_average_wait.sv -----
// fcfs_sjf_average_wait: top level, burst store, pair sequencer and a shared
// restoring divider; depends on fsaw_pkg
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_ready    | burst_time, last_burst
//  output   | out_valid / out_ready  | avg_wait, avg_turnaround, overflow
//  config   | cfg_valid / cfg_ready  | policy_mode
//
// bursts load one beat per cycle while in_ready is high.
// after the last beat of a set the block is busy for the pair pass (each pair
// read through the two-port store, then accumulated) and two passes of the
// one-bit-per-cycle divider (wait, then turnaround), then a finish state.
// the finish cycle waits while an earlier result is still held on the output.
// reset is asynchronous; the store holds no reset and needs no clearing pass.
`default_nettype none

module fcfs_sjf_average_wait #(
    parameter int MAX_PROCS = fsaw_pkg::MAX_PROCS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [fsaw_pkg::BURST_W-1:0] burst_time,
    input  wire logic                       last_burst,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [fsaw_pkg::AVG_W-1:0]      avg_wait,
    output logic [fsaw_pkg::AVG_W-1:0]      avg_turnaround,
    output logic                            overflow,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       policy_mode
);

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int RAW_W  = fsaw_pkg::BURST_W + 2 * CNT_W;
    localparam int SUM_W  = (RAW_W > fsaw_pkg::AVG_W) ? RAW_W : fsaw_pkg::AVG_W + 1;
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int AW     = fsaw_pkg::AVG_W;
    localparam int BW     = fsaw_pkg::BURST_W;

    fsaw_pkg::state_t state_reg, state_next;

    logic [BW-1:0]     mem [MAX_PROCS];
    logic [BW-1:0]     rd_a_reg, rd_b_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [SUM_W-1:0]  wait_reg, wait_next;
    logic [SUM_W-1:0]  burst_reg, burst_next;
    logic [SUM_W-1:0]  dq_reg, dq_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] bit_reg, bit_next;
    logic              phase_reg, phase_next;
    logic              drop_reg, drop_next;
    logic              mode_reg;
    logic [AW-1:0]     wq_reg, wq_next;
    logic [AW-1:0]     tq_reg, tq_next;
    logic              ovalid_reg, ovalid_next;
    logic [AW-1:0]     owait_reg, owait_next;
    logic [AW-1:0]     oturn_reg, oturn_next;
    logic              oovf_reg, oovf_next;

    logic              in_fire;
    logic              room;
    logic              pair_last_j;
    logic              pair_last_i;
    logic              div_last;
    logic              fin_go;
    logic [CNT_W:0]    trial;
    logic              trial_ge;
    logic [SUM_W-1:0]  dq_shift;
    logic [AW-1:0]     q_sat;
    logic [BW-1:0]     pick;

    assign in_ready  = (state_reg == fsaw_pkg::ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign room      = (count_reg < CNT_W'(MAX_PROCS));

    assign pair_last_j = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign pair_last_i = ((CNT_W'(i_reg) + CNT_W'(2)) == count_reg);
    assign div_last    = (bit_reg == DCNT_W'(SUM_W - 1));
    assign fin_go      = !ovalid_reg || out_ready;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, dq_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, count_reg});
    assign dq_shift = {dq_reg[SUM_W-2:0], trial_ge};
    assign q_sat    = (|dq_shift[SUM_W-1:AW]) ? {AW{1'b1}} : dq_shift[AW-1:0];

    // sjf wait total is the sum over pairs of the smaller burst
    assign pick = (mode_reg && (rd_b_reg < rd_a_reg)) ? rd_b_reg : rd_a_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsaw_pkg::ST_LOAD:
            begin
                if (in_fire && last_burst)
                begin
                    if (count_next >= CNT_W'(2))
                        state_next = fsaw_pkg::ST_RD;
                    else
                        state_next = fsaw_pkg::ST_DIV;
                end
            end
            fsaw_pkg::ST_RD:
                state_next = fsaw_pkg::ST_ACC;
            fsaw_pkg::ST_ACC:
            begin
                if (pair_last_j && pair_last_i)
                    state_next = fsaw_pkg::ST_DIV;
                else
                    state_next = fsaw_pkg::ST_RD;
            end
            fsaw_pkg::ST_DIV:
            begin
                if (div_last && phase_reg)
                    state_next = fsaw_pkg::ST_FIN;
            end
            fsaw_pkg::ST_FIN:
            begin
                if (fin_go)
                    state_next = fsaw_pkg::ST_LOAD;
            end
            default:
                state_next = fsaw_pkg::ST_LOAD;
        endcase
    end

    // datapath and output values
    always_comb
    begin
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        wait_next   = wait_reg;
        burst_next  = burst_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        phase_next  = phase_reg;
        drop_next   = drop_reg;
        wq_next     = wq_reg;
        tq_next     = tq_reg;
        ovalid_next = ovalid_reg && !out_ready;
        owait_next  = owait_reg;
        oturn_next  = oturn_reg;
        oovf_next   = oovf_reg;
        case (state_reg)
            fsaw_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        burst_next = burst_reg + SUM_W'(burst_time);
                    end
                    else
                        drop_next = 1'b1;
                end
                i_next    = '0;
                j_next    = IDX_W'(1);
                wait_next = '0;
                dq_next   = '0;
                rem_next  = '0;
                bit_next  = '0;
                phase_next = 1'b0;
            end
            fsaw_pkg::ST_RD:
            begin
            end
            fsaw_pkg::ST_ACC:
            begin
                wait_next = wait_reg + SUM_W'(pick);
                if (pair_last_j)
                begin
                    i_next = i_reg + IDX_W'(1);
                    j_next = i_reg + IDX_W'(2);
                end
                else
                    j_next = j_reg + IDX_W'(1);
                dq_next = wait_reg + SUM_W'(pick);
            end
            fsaw_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
                dq_next  = dq_shift;
                bit_next = bit_reg + DCNT_W'(1);
                if (div_last)
                begin
                    bit_next = '0;
                    rem_next = '0;
                    if (!phase_reg)
                    begin
                        wq_next    = q_sat;
                        dq_next    = wait_reg + burst_reg;
                        phase_next = 1'b1;
                    end
                    else
                        tq_next = q_sat;
                end
            end
            fsaw_pkg::ST_FIN:
            begin
                if (fin_go)
                begin
                    ovalid_next = 1'b1;
                    oovf_next   = drop_reg;
                    owait_next  = (count_reg == '0) ? '0 : wq_reg;
                    oturn_next  = (count_reg == '0) ? '0 : tq_reg;
                    count_next  = '0;
                    burst_next  = '0;
                    drop_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fsaw_pkg::ST_LOAD;
            count_reg  <= '0;
            burst_reg  <= '0;
            wait_reg   <= '0;
            drop_reg   <= 1'b0;
            mode_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
            bit_reg    <= '0;
            i_reg      <= '0;
            j_reg      <= IDX_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            burst_reg  <= burst_next;
            wait_reg   <= wait_next;
            drop_reg   <= drop_next;
            ovalid_reg <= ovalid_next;
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= policy_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        wq_reg    <= wq_next;
        tq_reg    <= tq_next;
        owait_reg <= owait_next;
        oturn_reg <= oturn_next;
        oovf_reg  <= oovf_next;
    end

    // burst store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (in_fire && room)
            mem[count_reg[IDX_W-1:0]] <= burst_time;
        rd_a_reg <= mem[i_reg];
        rd_b_reg <= mem[j_reg];
    end

    assign out_valid      = ovalid_reg;
    assign avg_wait       = owait_reg;
    assign avg_turnaround = oturn_reg;
    assign overflow       = oovf_reg;

endmodule

`default_nettype wire

// ----- hdl/fsaw_check.sv -----
// fsaw_check: port-level checks for fcfs_sjf_average_wait, bound to the top
// level below; depends on fsaw_pkg for field widths
`default_nettype none

module fsaw_check (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [fsaw_pkg::BURST_W-1:0] burst_time,
    input wire logic                         last_burst,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [fsaw_pkg::AVG_W-1:0]   avg_wait,
    input wire logic [fsaw_pkg::AVG_W-1:0]   avg_turnaround,
    input wire logic                         overflow
);

    // a closing beat always starts the busy phase
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_burst |=> !in_ready)
        else $error("input still ready after the closing beat");

    // a new result only appears after a busy phase
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a busy phase");

    // turnaround adds the bursts to the waits
    a_turn_ge_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> avg_turnaround >= avg_wait)
        else $error("average turnaround below average wait");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(avg_wait)
            && $stable(avg_turnaround) && $stable(overflow))
        else $error("stalled result changed");

endmodule

bind fcfs_sjf_average_wait fsaw_check u_fsaw_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .burst_time     (burst_time),
    .last_burst     (last_burst),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .avg_wait       (avg_wait),
    .avg_turnaround (avg_turnaround),
    .overflow       (overflow)
);

`default_nettype wire
